>>> rtl/core/pce_pkg.sv
package pce_pkg;

	localparam int PIECES = 3;
	localparam int ORDER  = 3;

	localparam int XW     = 16;
	localparam int REGW   = 64;
	localparam int HALFW  = 32;
	localparam int AW     = 45;
	localparam int DW     = XW + 1;
	localparam int FRAC   = 15;
	localparam int LO_W   = 24;
	localparam int HI_W   = AW - LO_W;
	localparam int PROD_W = AW + DW;
	localparam int IDXW   = 3;
	localparam int EW     = 2;
	localparam int PW     = (PIECES > 1) ? $clog2(PIECES) : 1;
	localparam int JW     = $clog2(ORDER + 1);
	localparam int STAGES = 2 * ORDER + 2;
	localparam int SUMW   = AW + $clog2(PIECES);
	localparam int RW     = 32;

	localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(2 ** (FRAC - 1));
	localparam logic [RW-1:0] RESP_MAX = 32'h7FFF_FFFF;
	localparam logic [RW-1:0] RESP_MIN = 32'h8000_0000;

	typedef logic signed [AW-1:0] acc_t;
	typedef logic signed [DW-1:0] dist_t;
	typedef logic [XW-1:0]        pos_t;
	typedef acc_t [ORDER:0]       coef_set_t;

	typedef struct packed {
		logic [REGW-1:0]              p0_low;
		logic [PIECES-1:0][REGW-1:0]  p_high;
		logic [REGW-1:0]              edges;
	} cfg_t;

	typedef enum logic [IDXW-1:0] {
		REG_P0_LOW  = 3'd0,
		REG_P0_HIGH = 3'd1,
		REG_P1_HIGH = 3'd2,
		REG_P2_HIGH = 3'd3,
		REG_EDGES   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_MUL,
		SEQ_ADD,
		SEQ_WRB
	} seq_state_t;

	function automatic acc_t half_at(logic [REGW-1:0] r, logic upper);
		logic signed [HALFW-1:0] h;
		h = upper ? r[REGW-1:HALFW] : r[HALFW-1:0];
		return acc_t'(h);
	endfunction

	function automatic pos_t edge_at(logic [REGW-1:0] edges, logic [EW-1:0] k);
		return edges[k * XW +: XW];
	endfunction

	function automatic coef_set_t piece_coefs(cfg_t cfg, logic [PW-1:0] p, acc_t d0, acc_t d1);
		coef_set_t c;
		c[0] = (p == '0) ? half_at(cfg.p0_low, 1'b0) : d0;
		c[1] = (p == '0) ? half_at(cfg.p0_low, 1'b1) : d1;
		for (int j = 2; j <= ORDER; j++) begin
			c[j] = half_at(cfg.p_high[p], j == 3);
		end
		return c;
	endfunction

	function automatic acc_t times_small(acc_t c, logic [JW-1:0] j);
		acc_t r;
		r = '0;
		for (int b = 0; b < JW; b++) begin
			if (j[b]) begin
				r = r + (c <<< b);
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/piecewise_cubic_c1_evaluator.sv
// Evaluates a three-piece cubic with continuous value and slope at each unsigned Q1.15 point
// cos_angle and returns the sum of every piece whose [edge i, edge i+1) interval holds it,
// as signed Q16.16 saturated to 32 bits with clipped set on saturation; last_point rides
// along as last_result. One item is accepted per clock while in_stall is low: the table
// is ready and out_stall lets the pipeline move. The pipeline holds the ORDER Horner steps
// of each piece lane, each a split multiply stage and a round-and-add stage, plus an input
// and a sum/saturate stage. The joined pieces' constant and linear terms are derived from
// the registers by a sequencer that runs one shared multiplier through the Horner steps:
// after any configuration write in_stall stays high while that table is rebuilt.
module piecewise_cubic_c1_evaluator import pce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDXW-1:0]   cfg_index,
	input  logic [REGW-1:0]   cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [XW-1:0]     cos_angle,
	input  logic              last_point,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [RW-1:0] response,
	output logic              clipped,
	output logic              last_result
);

	cfg_t                     cfg_q;
	logic                     cfg_wr;
	logic                     seq_ready;
	acc_t                     dc0 [0:PIECES-1];
	acc_t                     dc1 [0:PIECES-1];
	logic [STAGES+1:1]        ld;
	logic [STAGES:1]          stage_valid_q;
	logic                     last_s [1:STAGES];
	logic                     in_take;
	acc_t                     lane_val [0:PIECES-1];
	logic signed [SUMW-1:0]   sum;
	logic                     sat;
	logic [RW-1:0]            resp_n;
	logic [RW-1:0]            resp_q;
	logic                     clip_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx_t'(cfg_index))
				REG_P0_LOW:  cfg_q.p0_low    <= cfg_data;
				REG_P0_HIGH: cfg_q.p_high[0] <= cfg_data;
				REG_P1_HIGH: cfg_q.p_high[1] <= cfg_data;
				REG_P2_HIGH: begin
					if (PIECES > 2) begin
						cfg_q.p_high[PIECES-1] <= cfg_data;
					end
				end
				REG_EDGES:   cfg_q.edges     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pce_coef_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cfg_wr (cfg_wr),
		.ready  (seq_ready),
		.dc0    (dc0),
		.dc1    (dc1)
	);

	always_comb begin
		ld[STAGES+1] = !out_stall;
		for (int k = STAGES; k >= 1; k--) begin
			ld[k] = !stage_valid_q[k] || ld[k+1];
		end
	end

	assign in_take  = in_valid && seq_ready;
	assign in_stall = !(ld[1] && seq_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (ld[1]) begin
				stage_valid_q[1] <= in_take;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (ld[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			last_s[1] <= last_point;
		end
		for (int k = 2; k <= STAGES; k++) begin
			if (ld[k]) begin
				last_s[k] <= last_s[k-1];
			end
		end
	end

	for (genvar i = 0; i < PIECES; i++) begin : g_lane
		pce_lane u_lane (
			.clk (clk),
			.ld  (ld[STAGES:1]),
			.x   (cos_angle),
			.lo  (edge_at(cfg_q.edges, EW'(i))),
			.hi  (edge_at(cfg_q.edges, EW'(i + 1))),
			.cs  (piece_coefs(cfg_q, PW'(i), dc0[i], dc1[i])),
			.val (lane_val[i])
		);
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < PIECES; i++) begin
			sum = sum + SUMW'(lane_val[i]);
		end
		sat = !((&sum[SUMW-1:RW-1]) || !(|sum[SUMW-1:RW-1]));
		if (sat) begin
			resp_n = sum[SUMW-1] ? RESP_MIN : RESP_MAX;
		end else begin
			resp_n = sum[RW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[STAGES]) begin
			resp_q <= resp_n;
			clip_q <= sat;
		end
	end

	assign out_valid   = stage_valid_q[STAGES];
	assign response    = resp_q;
	assign clipped     = clip_q;
	assign last_result = last_s[STAGES];

	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |-> (resp_q == RESP_MAX || resp_q == RESP_MIN))
		else $error("clipped item does not sit at a rail");

	a_take_needs_table: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> stage_valid_q[1])
		else $error("accepted item did not enter the first stage");

endmodule

>>> rtl/core/pce_mulr.sv
module pce_mulr import pce_pkg::*; (
	input  logic  clk,
	input  logic  en_a,
	input  logic  en_b,
	input  acc_t  a,
	input  dist_t b,
	input  acc_t  addend,
	output acc_t  q
);

	logic signed [LO_W:0]        a_lo;
	logic signed [HI_W-1:0]      a_hi;
	logic signed [LO_W+DW:0]     pl_q;
	logic signed [HI_W+DW-1:0]   ph_q;
	acc_t                        ad_q;
	logic signed [PROD_W-1:0]    prod;
	logic signed [PROD_W-1:0]    sh;
	acc_t                        q_n;
	acc_t                        q_q;

	assign a_lo = $signed({1'b0, a[LO_W-1:0]});
	assign a_hi = a[AW-1:LO_W];

	always_ff @(posedge clk) begin
		if (en_a) begin
			pl_q <= a_lo * b;
			ph_q <= a_hi * b;
			ad_q <= addend;
		end
	end

	always_comb begin
		prod = (PROD_W'(ph_q) <<< LO_W) + PROD_W'(pl_q);
		sh   = (prod + RND_BIAS) >>> FRAC;
		q_n  = acc_t'(sh[AW-1:0]) + ad_q;
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			q_q <= q_n;
		end
	end

	assign q = q_q;

endmodule

>>> rtl/core/pce_lane.sv
module pce_lane import pce_pkg::*; (
	input  logic              clk,
	input  logic [STAGES:1]   ld,
	input  pos_t              x,
	input  pos_t              lo,
	input  pos_t              hi,
	input  coef_set_t         cs,
	output acc_t              val
);

	localparam int LAST = 2 * ORDER + 1;

	dist_t dist_s [1:LAST];
	logic  hit_s  [1:LAST];
	acc_t  step_q [0:ORDER];

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			dist_s[1] <= $signed({1'b0, x}) - $signed({1'b0, lo});
			hit_s[1]  <= (x >= lo) && (x < hi);
		end
		for (int m = 2; m <= LAST; m++) begin
			if (ld[m]) begin
				dist_s[m] <= dist_s[m-1];
				hit_s[m]  <= hit_s[m-1];
			end
		end
	end

	assign step_q[0] = cs[ORDER];

	for (genvar k = 1; k <= ORDER; k++) begin : g_step
		pce_mulr u_mulr (
			.clk    (clk),
			.en_a   (ld[2*k]),
			.en_b   (ld[2*k+1]),
			.a      (step_q[k-1]),
			.b      (dist_s[2*k-1]),
			.addend (cs[ORDER-k]),
			.q      (step_q[k])
		);
	end

	assign val = hit_s[LAST] ? step_q[ORDER] : '0;

endmodule

>>> rtl/core/pce_coef_seq.sv
module pce_coef_seq import pce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cfg_wr,
	output logic ready,
	output acc_t dc0 [0:PIECES-1],
	output acc_t dc1 [0:PIECES-1]
);

	seq_state_t      state_q, state_n;
	logic            dirty_q, dirty_n;
	logic [PW-1:0]   p_q, p_n;
	logic [JW-1:0]   j_q, j_n;
	logic            slope_q, slope_n;
	logic            first_q, first_n;
	logic            wr0, wr1;
	acc_t            dc0_q [0:PIECES-1];
	acc_t            dc1_q [0:PIECES-1];
	coef_set_t       cs;
	pos_t            e_lo, e_hi;
	dist_t           len;
	acc_t            init, addend, mul_a, q;

	assign cs   = piece_coefs(cfg, p_q, dc0_q[p_q], dc1_q[p_q]);
	assign e_lo = edge_at(cfg.edges, EW'(p_q));
	assign e_hi = edge_at(cfg.edges, EW'(p_q) + EW'(1));
	assign len  = $signed({1'b0, e_hi}) - $signed({1'b0, e_lo});

	assign init   = slope_q ? times_small(cs[ORDER], JW'(ORDER)) : cs[ORDER];
	assign addend = slope_q ? times_small(cs[j_q], j_q) : cs[j_q];
	assign mul_a  = first_q ? init : q;

	pce_mulr u_mulr (
		.clk    (clk),
		.en_a   (state_q == SEQ_MUL),
		.en_b   (state_q == SEQ_ADD),
		.a      (mul_a),
		.b      (len),
		.addend (addend),
		.q      (q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			dirty_q <= 1'b0;
			p_q     <= '0;
			j_q     <= '0;
			slope_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_n;
			dirty_q <= dirty_n;
			p_q     <= p_n;
			j_q     <= j_n;
			slope_q <= slope_n;
			first_q <= first_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIECES; i++) begin
				dc0_q[i] <= '0;
				dc1_q[i] <= '0;
			end
		end else begin
			if (wr0) begin
				dc0_q[p_q + PW'(1)] <= q;
			end
			if (wr1) begin
				dc1_q[p_q + PW'(1)] <= q;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		dirty_n = dirty_q;
		p_n     = p_q;
		j_n     = j_q;
		slope_n = slope_q;
		first_n = first_q;
		wr0     = 1'b0;
		wr1     = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				if (dirty_q) begin
					dirty_n = 1'b0;
					p_n     = '0;
					j_n     = JW'(ORDER - 1);
					slope_n = 1'b0;
					first_n = 1'b1;
					state_n = SEQ_MUL;
				end
			end
			SEQ_MUL: begin
				first_n = 1'b0;
				state_n = SEQ_ADD;
			end
			SEQ_ADD: begin
				if (j_q == JW'(slope_q)) begin
					state_n = SEQ_WRB;
				end else begin
					j_n     = j_q - JW'(1);
					state_n = SEQ_MUL;
				end
			end
			SEQ_WRB: begin
				j_n     = JW'(ORDER - 1);
				first_n = 1'b1;
				if (!slope_q) begin
					wr0     = 1'b1;
					slope_n = 1'b1;
					state_n = SEQ_MUL;
				end else begin
					wr1     = 1'b1;
					slope_n = 1'b0;
					if (p_q == PW'(PIECES - 2)) begin
						state_n = SEQ_IDLE;
					end else begin
						p_n     = p_q + PW'(1);
						state_n = SEQ_MUL;
					end
				end
			end
			default: begin
				state_n = SEQ_IDLE;
			end
		endcase
		if (cfg_wr) begin
			state_n = SEQ_IDLE;
			dirty_n = 1'b1;
		end
	end

	assign ready = (state_q == SEQ_IDLE) && !dirty_q;
	assign dc0   = dc0_q;
	assign dc1   = dc1_q;

	a_wr_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !ready)
		else $error("coefficient table reported ready right after a write");

	a_add_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_ADD) |-> ($past(state_q) == SEQ_MUL))
		else $error("accumulate step without a preceding multiply");

	a_piece_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != SEQ_IDLE) |-> (p_q <= PW'(PIECES - 2)))
		else $error("derivation ran past the last joined piece");

	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != SEQ_IDLE) |-> (j_q <= JW'(ORDER - 1)))
		else $error("Horner term index out of range");

endmodule
